// File: rtl/puct_child_select_defines.svh
// Assertion macros shared by the PUCT child selector RTL.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef PUCT_CHILD_SELECT_DEFINES_SVH
`define PUCT_CHILD_SELECT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pcs_pkg.sv
// Shared widths, constants and handshake structs of the PUCT child selector.
// Depends on nothing; used by pcs_divider, pcs_isqrt and puct_child_select.
package pcs_pkg;

  localparam int GAIN_W     = 16;
  localparam int VISITS_W   = 20;
  localparam int ACTION_W   = 8;
  localparam int VSUM_W     = 32;
  localparam int PRIOR_W    = 16;
  localparam int SCORE_W    = 48;

  // Square root: radicand is max(parent_visits,1) in Q20.16, root is Q10.8.
  localparam int ROOT_IN_W  = 36;
  localparam int ROOT_W     = 18;
  localparam int ROOT_CNT_W = 5;

  // Shared divider: numerator left-aligned in DIV_NUM_W bits.
  localparam int DIV_NUM_W  = 50;
  localparam int DIV_DEN_W  = 21;
  localparam int DIV_CNT_W  = 6;
  localparam int QNUM_W     = 36;
  localparam int U_SHIFT    = 20;

  localparam logic [DIV_CNT_W-1:0] Q_STEPS = 6'd36;
  localparam logic [DIV_CNT_W-1:0] U_STEPS = 6'd50;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd6144;
  localparam logic [SCORE_W-1:0] SCORE_MIN  = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/pcs_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by q and u.
// Depends on pcs_pkg for widths and the request/response structs.
module pcs_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  pcs_pkg::div_req_t req,
  output pcs_pkg::div_rsp_t rsp
);

  logic [pcs_pkg::DIV_NUM_W-1:0] num_r;
  logic [pcs_pkg::DIV_DEN_W-1:0] den_r;
  logic [pcs_pkg::DIV_DEN_W-1:0] rem_r;
  logic [pcs_pkg::DIV_NUM_W-1:0] quot_r;
  logic [pcs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;

  logic [pcs_pkg::DIV_DEN_W:0] rem_sh;
  logic [pcs_pkg::DIV_DEN_W:0] diff;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_r, num_r[pcs_pkg::DIV_NUM_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= req.steps;
        run_r  <= 1'b1;
      end else if (run_r) begin
        num_r  <= {num_r[pcs_pkg::DIV_NUM_W-2:0], 1'b0};
        rem_r  <= ge ? diff[pcs_pkg::DIV_DEN_W-1:0] : rem_sh[pcs_pkg::DIV_DEN_W-1:0];
        quot_r <= {quot_r[pcs_pkg::DIV_NUM_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/pcs_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on pcs_pkg for widths.
module pcs_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [pcs_pkg::ROOT_IN_W-1:0] radicand,
  output logic                          done,
  output logic [pcs_pkg::ROOT_W-1:0]    root
);

  logic [pcs_pkg::ROOT_IN_W-1:0]  rad_r;
  logic [pcs_pkg::ROOT_W+1:0]     rem_r;
  logic [pcs_pkg::ROOT_W-1:0]     root_r;
  logic [pcs_pkg::ROOT_CNT_W-1:0] cnt_r;
  logic                           run_r;
  logic                           done_r;

  logic [pcs_pkg::ROOT_W+3:0] rem_sh;
  logic [pcs_pkg::ROOT_W+3:0] trial;
  logic [pcs_pkg::ROOT_W+3:0] diff;
  logic                       ge;

  always_comb begin
    rem_sh = {rem_r, rad_r[pcs_pkg::ROOT_IN_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= pcs_pkg::ROOT_CNT_W'(pcs_pkg::ROOT_W);
        run_r  <= 1'b1;
      end else if (run_r) begin
        rad_r  <= {rad_r[pcs_pkg::ROOT_IN_W-3:0], 2'b00};
        rem_r  <= ge ? diff[pcs_pkg::ROOT_W+1:0] : rem_sh[pcs_pkg::ROOT_W+1:0];
        root_r <= {root_r[pcs_pkg::ROOT_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/puct_child_select.sv
// Top level of the PUCT child selector: sequencer, multipliers and best-child tracking.
// Depends on pcs_pkg, pcs_divider, pcs_isqrt and puct_child_select_defines.svh.
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  ---------------------------
//   request   in_* fields                             start, accepted if !busy
//   result    out_pick_action, out_child_found        out_valid, one-cycle strobe
//   config    cfg_wr_data (exploration_gain)          cfg_wr_en, no wait
//
// An empty slot passes only through the check and finish states. A present child takes
// the two multiplier states, a 36-step signed q division (skipped for an unvisited
// child) and a 50-step u division on the one shared radix-2 divider. The first slot
// of a run adds the 18-step square root of the parent visit count.
// Reset is synchronous, active low, and returns the gain to 1.5 with no run open.
// The receiver cannot stall: out_valid is high for one cycle after the last slot.
`include "puct_child_select_defines.svh"

module puct_child_select (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration port.
  input  logic                         cfg_wr_en,
  input  logic [pcs_pkg::GAIN_W-1:0]   cfg_wr_data,
  // Request channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [pcs_pkg::VISITS_W-1:0] in_parent_visits,
  input  logic [pcs_pkg::ACTION_W-1:0] in_slot_action,
  input  logic                         in_child_present,
  input  logic [pcs_pkg::VISITS_W-1:0] in_child_visits,
  input  logic signed [pcs_pkg::VSUM_W-1:0] in_child_vsum,
  input  logic [pcs_pkg::PRIOR_W-1:0]  in_child_prior,
  input  logic                         in_last_slot,
  // Result channel.
  output logic                         out_valid,
  output logic [pcs_pkg::ACTION_W-1:0] out_pick_action,
  output logic                         out_child_found
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT_WAIT,
    S_CHECK,
    S_MUL_A,
    S_MUL_B,
    S_QSTART,
    S_DIVQ_WAIT,
    S_DIVU_WAIT,
    S_FINISH
  } state_t;

  state_t state_r;

  // Exploration gain register.
  logic [pcs_pkg::GAIN_W-1:0] gain_r;

  // Latched request fields.
  logic [pcs_pkg::ACTION_W-1:0] action_r;
  logic                         present_r;
  logic [pcs_pkg::VISITS_W-1:0] visits_r;
  logic signed [pcs_pkg::VSUM_W-1:0] vsum_r;
  logic [pcs_pkg::PRIOR_W-1:0]  prior_r;
  logic                         last_r;

  // Run state.
  logic                              in_run_r;
  logic [pcs_pkg::ROOT_W-1:0]        root_r;
  logic signed [pcs_pkg::SCORE_W-1:0] best_score_r;
  logic [pcs_pkg::ACTION_W-1:0]      best_index_r;
  logic                              any_found_r;

  // Arithmetic pipeline registers.
  logic [2*pcs_pkg::GAIN_W-1:0]       gp_r;
  logic [pcs_pkg::DIV_NUM_W-1:0]      prod_r;
  logic signed [pcs_pkg::SCORE_W-1:0] q_r;

  // Unit control and results.
  logic                          sqrt_go_r;
  logic [pcs_pkg::ROOT_IN_W-1:0] radicand_r;
  logic                          sqrt_done;
  logic [pcs_pkg::ROOT_W-1:0]    sqrt_root;
  pcs_pkg::div_req_t             div_req_r;
  pcs_pkg::div_rsp_t             div_rsp;

  // Output registers.
  logic                         out_valid_r;
  logic [pcs_pkg::ACTION_W-1:0] out_action_r;
  logic                         out_found_r;

  // Combinational helpers.
  logic                              accept;
  logic [pcs_pkg::VISITS_W-1:0]      pv_clamped;
  logic [pcs_pkg::QNUM_W-1:0]        vsum16;
  logic [pcs_pkg::QNUM_W-1:0]        vsum_abs;
  logic signed [pcs_pkg::SCORE_W-1:0] q_mag;
  logic signed [pcs_pkg::SCORE_W-1:0] u_val;
  logic signed [pcs_pkg::SCORE_W-1:0] score;
  logic                              take;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    pv_clamped = (in_parent_visits == '0) ? pcs_pkg::VISITS_W'(1) : in_parent_visits;
    // The value total scaled by 16 to a Q20.16 numerator, then its magnitude for
    // the unsigned divider; the most negative sum maps to 2^35, which still fits.
    vsum16   = {vsum_r, 4'b0000};
    vsum_abs = vsum_r[pcs_pkg::VSUM_W-1] ? (~vsum16 + 1'b1) : vsum16;
    q_mag    = {{(pcs_pkg::SCORE_W-pcs_pkg::QNUM_W){1'b0}},
                div_rsp.quot[pcs_pkg::QNUM_W-1:0]};
    // u keeps only the quotient bits above the Q20 fraction.
    u_val    = {{(pcs_pkg::SCORE_W-(pcs_pkg::DIV_NUM_W-pcs_pkg::U_SHIFT)){1'b0}},
                div_rsp.quot[pcs_pkg::DIV_NUM_W-1:pcs_pkg::U_SHIFT]};
    score    = q_r + u_val;
    take     = !any_found_r || (score > best_score_r);
  end

  pcs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sqrt_go_r),
    .radicand (radicand_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  pcs_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= pcs_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // Sequencer: one slot at a time, handing work to the root unit and the
  // shared divider and waiting for each to finish.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      in_run_r        <= 1'b0;
      any_found_r     <= 1'b0;
      best_score_r    <= pcs_pkg::SCORE_MIN;
      best_index_r    <= '0;
      sqrt_go_r       <= 1'b0;
      div_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      sqrt_go_r       <= 1'b0;
      div_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            action_r  <= in_slot_action;
            present_r <= in_child_present;
            visits_r  <= in_child_visits;
            vsum_r    <= in_child_vsum;
            prior_r   <= in_child_prior;
            last_r    <= in_last_slot;
            if (!in_run_r) begin
              // First slot of a run: open the run and take the parent root.
              in_run_r     <= 1'b1;
              any_found_r  <= 1'b0;
              best_score_r <= pcs_pkg::SCORE_MIN;
              best_index_r <= '0;
              radicand_r   <= {pv_clamped, 16'h0000};
              sqrt_go_r    <= 1'b1;
              state_r      <= S_ROOT_WAIT;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_ROOT_WAIT: begin
          if (sqrt_done) begin
            root_r  <= sqrt_root;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_r <= present_r ? S_MUL_A : S_FINISH;
        end
        S_MUL_A: begin
          gp_r    <= gain_r * prior_r;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_r  <= pcs_pkg::DIV_NUM_W'(gp_r * root_r);
          state_r <= S_QSTART;
        end
        S_QSTART: begin
          div_req_r.start <= 1'b1;
          if (visits_r != '0) begin
            div_req_r.num   <= {vsum_abs, {(pcs_pkg::DIV_NUM_W-pcs_pkg::QNUM_W){1'b0}}};
            div_req_r.den   <= {1'b0, visits_r};
            div_req_r.steps <= pcs_pkg::Q_STEPS;
            state_r         <= S_DIVQ_WAIT;
          end else begin
            // No visits: q is zero and only u is needed.
            q_r             <= '0;
            div_req_r.num   <= prod_r;
            div_req_r.den   <= {1'b0, visits_r} + 1'b1;
            div_req_r.steps <= pcs_pkg::U_STEPS;
            state_r         <= S_DIVU_WAIT;
          end
        end
        S_DIVQ_WAIT: begin
          if (div_rsp.done) begin
            // q = -(vsum*16 / visits), truncated toward zero.
            q_r             <= vsum_r[pcs_pkg::VSUM_W-1] ? q_mag : -q_mag;
            div_req_r.start <= 1'b1;
            div_req_r.num   <= prod_r;
            div_req_r.den   <= {1'b0, visits_r} + 1'b1;
            div_req_r.steps <= pcs_pkg::U_STEPS;
            state_r         <= S_DIVU_WAIT;
          end
        end
        S_DIVU_WAIT: begin
          if (div_rsp.done) begin
            // Strictly greater wins, so the earliest slot keeps a tie.
            if (take) begin
              best_score_r <= score;
              best_index_r <= action_r;
              any_found_r  <= 1'b1;
            end
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (last_r) begin
            out_valid_r  <= 1'b1;
            out_action_r <= any_found_r ? best_index_r : '0;
            out_found_r  <= any_found_r;
            in_run_r     <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pick_action = out_action_r;
  assign out_child_found = out_found_r;

  `PCS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted request not busy")
  `PCS_ASSERT_SAME(a_result_closes_run, out_valid, !in_run_r, "result with run open")
  `PCS_ASSERT_SAME(a_empty, out_valid && !out_child_found, out_pick_action == '0, "empty pick")
  `PCS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "strobe longer than a cycle")

endmodule

// File: dv/puct_child_select_test.sv
// Self-checking testbench for puct_child_select: sends runs of child-slot requests and
// checks every best-child pick against a behavioral PUCT scorer kept in this file.
// Depends on pcs_pkg and the puct_child_select RTL; it reads and writes no files.
module puct_child_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest item is a present child on the first slot of a run, plus its idle gap.
  // About 1360 items are sent, so the limit below leaves several times their worst case.
  localparam int CYCLE_LIMIT   = 800000;
  // Quiet time after the last pick of a phase, well above the longest slot latency.
  localparam int SETTLE_CYCLES = 200;
  // Least number of random requests per gain setting; a phase ends on a whole run.
  localparam int PHASE_SLOTS   = 260;

  localparam logic [pcs_pkg::VISITS_W-1:0]      VISITS_MAX = '1;
  localparam logic [pcs_pkg::ACTION_W-1:0]      ACTION_MAX = '1;
  localparam logic [pcs_pkg::PRIOR_W-1:0]       PRIOR_MAX  = '1;
  localparam logic [pcs_pkg::GAIN_W-1:0]        GAIN_MAX   = '1;
  localparam logic signed [pcs_pkg::VSUM_W-1:0] VSUM_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [pcs_pkg::VSUM_W-1:0] VSUM_MIN   = 32'sh8000_0000;
  localparam logic signed [pcs_pkg::VSUM_W-1:0] VSUM_ONE   = 32'sd4096;    // 1.0 in Q20.12
  localparam longint SCORE_FLOOR = -(longint'(1) << (pcs_pkg::SCORE_W - 1));

  // One child slot, as carried by one request.
  typedef struct {
    logic [pcs_pkg::VISITS_W-1:0]      parent_visits;
    logic [pcs_pkg::ACTION_W-1:0]      action;
    logic                              present;
    logic [pcs_pkg::VISITS_W-1:0]      visits;
    logic signed [pcs_pkg::VSUM_W-1:0] vsum;
    logic [pcs_pkg::PRIOR_W-1:0]       prior;
    logic                              last;
  } slot_t;

  // The pick the block should report at the end of a run.
  typedef struct {
    logic [pcs_pkg::ACTION_W-1:0] action;
    logic                         found;
  } pick_t;

  // Every block input holds a known value from time zero.
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [pcs_pkg::GAIN_W-1:0]        cfg_wr_data = '0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [pcs_pkg::VISITS_W-1:0]      in_parent_visits = '0;
  logic [pcs_pkg::ACTION_W-1:0]      in_slot_action = '0;
  logic                              in_child_present = 1'b0;
  logic [pcs_pkg::VISITS_W-1:0]      in_child_visits = '0;
  logic signed [pcs_pkg::VSUM_W-1:0] in_child_vsum = '0;
  logic [pcs_pkg::PRIOR_W-1:0]       in_child_prior = '0;
  logic                              in_last_slot = 1'b0;
  logic                              out_valid;
  logic [pcs_pkg::ACTION_W-1:0]      out_pick_action;
  logic                              out_child_found;

  // Scorer state: gain register, running best of the open run, and the parent root.
  logic [pcs_pkg::GAIN_W-1:0]        gain_q4_12 = pcs_pkg::GAIN_RESET;
  longint                            best_so_far = SCORE_FLOOR;
  logic [pcs_pkg::ACTION_W-1:0]      lead_action = '0;
  bit                                child_seen = 1'b0;
  bit                                node_open = 1'b0;
  longint unsigned                   root_q8 = 0;
  pick_t                             pending_picks[$];

  int slots_sent = 0;
  int nodes_sent = 0;
  int picks_checked = 0;
  int gain_writes = 0;
  int mismatches = 0;
  int cycles = 0;

  puct_child_select u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_parent_visits (in_parent_visits),
    .in_slot_action   (in_slot_action),
    .in_child_present (in_child_present),
    .in_child_visits  (in_child_visits),
    .in_child_vsum    (in_child_vsum),
    .in_child_prior   (in_child_prior),
    .in_last_slot     (in_last_slot),
    .out_valid        (out_valid),
    .out_pick_action  (out_pick_action),
    .out_child_found  (out_child_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost pick ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d picks still pending", $time,
               cycles, pending_picks.size());
      $display("puct_child_select_test failed");
      $finish;
    end
  end

  // Score one accepted slot and advance the running best. The first slot of a run
  // latches floor(sqrt(max(parent_visits,1))) in Q10.8; later slots ignore the
  // parent count. q = -(vsum * 16 / visits) truncates toward zero and is zero
  // for an unvisited child; u = gain * prior * root / (1 + visits), floored, then
  // scaled down by 2^20 to Q14.16. A strictly greater score replaces the best, so the
  // earliest slot keeps a tie, and the first present child is always taken.
  task automatic track_slot(input slot_t s);
    longint unsigned radicand;
    longint unsigned trial;
    longint unsigned prod;
    longint unsigned u;
    longint          q;
    longint          score;
    pick_t           pick;
    if (!node_open) begin
      radicand = (s.parent_visits > 20'd1) ? 64'(s.parent_visits) : 64'd1;
      radicand = radicand << 16;
      root_q8 = 64'd0;
      // The radicand is below 2^36, so the root fits in 18 bits.
      for (int b = 17; b >= 0; b--) begin
        trial = root_q8 | (64'd1 << b);
        if (trial * trial <= radicand) root_q8 = trial;
      end
      best_so_far = SCORE_FLOOR;
      lead_action = '0;
      child_seen = 1'b0;
      node_open = 1'b1;
    end
    if (s.present) begin
      q = 0;
      if (s.visits != 0) q = -((longint'(s.vsum) * 16) / longint'(s.visits));
      // The product stays below 2^50, so 64 unsigned bits hold it exactly.
      prod = 64'(gain_q4_12);
      prod = prod * 64'(s.prior);
      prod = prod * root_q8;
      u = (prod / (64'd1 + 64'(s.visits))) >> pcs_pkg::U_SHIFT;
      score = q + longint'(u);
      if (!child_seen || score > best_so_far) begin
        best_so_far = score;
        lead_action = s.action;
        child_seen = 1'b1;
      end
    end
    if (s.last) begin
      pick.action = child_seen ? lead_action : '0;
      pick.found = child_seen;
      pending_picks.push_back(pick);
      node_open = 1'b0;
      nodes_sent++;
    end
  endtask

  // Present one request and hold it until the block takes it. The gap before it is
  // drawn per request; start stays high across back-to-back requests.
  task automatic send_slot(input slot_t s, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_parent_visits <= s.parent_visits;
    in_slot_action   <= s.action;
    in_child_present <= s.present;
    in_child_visits  <= s.visits;
    in_child_vsum    <= s.vsum;
    in_child_prior   <= s.prior;
    in_last_slot     <= s.last;
    // busy is read before this edge's updates land, so this is the value the block saw.
    do @(posedge clk); while (busy);
    track_slot(s);
    slots_sent++;
  endtask

  // Let every outstanding pick arrive, then give the block time to go fully idle.
  task automatic drain();
    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic set_gain(input logic [pcs_pkg::GAIN_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gain_q4_12 = value;
    gain_writes++;
  endtask

  function automatic slot_t make_slot(input logic [pcs_pkg::VISITS_W-1:0] pv,
                                      input logic [pcs_pkg::ACTION_W-1:0] act,
                                      input logic pres,
                                      input logic [pcs_pkg::VISITS_W-1:0] vis,
                                      input logic signed [pcs_pkg::VSUM_W-1:0] vsum,
                                      input logic [pcs_pkg::PRIOR_W-1:0] pri,
                                      input logic lst);
    slot_t s;
    s.parent_visits = pv;
    s.action = act;
    s.present = pres;
    s.visits = vis;
    s.vsum = vsum;
    s.prior = pri;
    s.last = lst;
    return s;
  endfunction

  // Runs of one slot, at the reset gain: field extremes and the empty node.
  task automatic test_single_slot_nodes();
    // Zero parent visits clamps to one; an unvisited child has q = 0.
    send_slot(make_slot('0, 8'd7, 1'b1, '0, '0, PRIOR_MAX, 1'b1), 1'b1);
    // An empty single slot gives child_found 0 and action 0.
    send_slot(make_slot(20'd50, 8'd200, 1'b0, 20'd3, VSUM_ONE, 16'd9, 1'b1), 1'b1);
    send_slot(make_slot(VISITS_MAX, ACTION_MAX, 1'b1, VISITS_MAX, VSUM_MAX, PRIOR_MAX,
                        1'b1), 1'b1);
    send_slot(make_slot(20'd1, '0, 1'b1, 20'd1, VSUM_MIN, '0, 1'b1), 1'b1);
    drain();
  endtask

  // Multi-slot runs: all empty, a tie, parent count sampled once, unvisited children.
  task automatic test_multi_slot_nodes();
    send_slot(make_slot(20'd9, 8'd1, 1'b0, 20'd1, VSUM_ONE, 16'd100, 1'b0), 1'b1);
    send_slot(make_slot(20'd9, 8'd2, 1'b0, '0, '0, '0, 1'b0), 1'b1);
    send_slot(make_slot(20'd9, 8'd3, 1'b0, VISITS_MAX, VSUM_MIN, PRIOR_MAX, 1'b1), 1'b1);
    // Two equal scores: the earlier slot must stay the pick.
    send_slot(make_slot(20'd400, 8'd3, 1'b1, 20'd5, -VSUM_ONE, 16'd30000, 1'b0), 1'b1);
    send_slot(make_slot(20'd400, 8'd9, 1'b1, 20'd5, -VSUM_ONE, 16'd30000, 1'b0), 1'b1);
    send_slot(make_slot(20'd400, 8'd77, 1'b0, '0, '0, '0, 1'b1), 1'b1);
    // Later slots carry a different parent count that the block must ignore.
    send_slot(make_slot(20'd100, 8'd1, 1'b1, 20'd4, '0, 16'd1000, 1'b0), 1'b1);
    send_slot(make_slot(VISITS_MAX, 8'd2, 1'b1, 20'd1, -VSUM_ONE, '0, 1'b0), 1'b1);
    send_slot(make_slot(VISITS_MAX, 8'd3, 1'b1, 20'd2, VSUM_ONE, 16'd40000, 1'b1), 1'b0);
    // A huge value sum with no visits scores zero; one loss-free visit beats it.
    send_slot(make_slot(20'd16, 8'd4, 1'b1, '0, VSUM_MIN, '0, 1'b0), 1'b0);
    send_slot(make_slot(20'd16, 8'd5, 1'b1, 20'd1, -VSUM_ONE, '0, 1'b1), 1'b0);
    drain();
  endtask

  // Gain at both ends of its range.
  task automatic test_gain_extremes();
    set_gain('0);
    send_slot(make_slot(VISITS_MAX, 8'd10, 1'b1, '0, '0, PRIOR_MAX, 1'b0), 1'b1);
    send_slot(make_slot(VISITS_MAX, 8'd11, 1'b1, 20'd3, -32'sd8192, '0, 1'b0), 1'b1);
    send_slot(make_slot(VISITS_MAX, 8'd12, 1'b1, 20'd1, 32'sd1, 16'd1, 1'b1), 1'b1);
    drain();
    set_gain(GAIN_MAX);
    send_slot(make_slot(VISITS_MAX, 8'd20, 1'b1, '0, '0, PRIOR_MAX, 1'b0), 1'b0);
    send_slot(make_slot(VISITS_MAX, 8'd21, 1'b1, VISITS_MAX, VSUM_MIN, PRIOR_MAX, 1'b0),
              1'b0);
    send_slot(make_slot(VISITS_MAX, 8'd22, 1'b0, '0, '0, '0, 1'b1), 1'b0);
    drain();
  endtask

  // Random runs under several gains. Most runs are short, some long, one well past
  // the nominal action count. Field values mix full range with small, score-sensitive
  // values, and some children copy the previous child's statistics to force ties.
  task automatic test_random_nodes();
    logic [pcs_pkg::GAIN_W-1:0] phase_gain [5];
    int                         len;
    int                         phase_base;
    bit                         idle;
    slot_t                      s;
    slot_t                      prev;
    phase_gain[0] = pcs_pkg::GAIN_W'($urandom_range(0, 65535));
    phase_gain[1] = '0;
    phase_gain[2] = GAIN_MAX;
    phase_gain[3] = 16'd4096;
    phase_gain[4] = pcs_pkg::GAIN_W'($urandom_range(1, 65535));
    prev = make_slot('0, '0, 1'b0, '0, '0, '0, 1'b0);
    for (int p = 0; p < 5; p++) begin
      set_gain(phase_gain[p]);
      phase_base = slots_sent;
      while (slots_sent - phase_base < PHASE_SLOTS) begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(9, 40);
          1: len = 1;
          default: len = $urandom_range(2, 8);
        endcase
        if (p == 2 && slots_sent == phase_base) len = 300;
        // About one run in four goes back to back with no idle cycles.
        idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0: s.parent_visits = pcs_pkg::VISITS_W'($urandom_range(0, 3));
            1: s.parent_visits = pcs_pkg::VISITS_W'($urandom_range(0, 1000));
            default: s.parent_visits = pcs_pkg::VISITS_W'($urandom_range(0, 20'hFFFFF));
          endcase
          s.action = pcs_pkg::ACTION_W'($urandom_range(0, 255));
          s.present = ($urandom_range(0, 3) != 0);
          case ($urandom_range(0, 3))
            0: s.visits = '0;
            1: s.visits = pcs_pkg::VISITS_W'($urandom_range(1, 16));
            2: s.visits = pcs_pkg::VISITS_W'($urandom_range(0, 1000));
            default: s.visits = pcs_pkg::VISITS_W'($urandom_range(0, 20'hFFFFF));
          endcase
          case ($urandom_range(0, 2))
            0: s.vsum = $urandom;
            1: s.vsum = $signed($urandom_range(0, 131072)) - 32'sd65536;
            default: s.vsum = '0;
          endcase
          s.prior = pcs_pkg::PRIOR_W'($urandom_range(0, 65535));
          if (prev.present && $urandom_range(0, 7) == 0) begin
            s.visits = prev.visits;
            s.vsum = prev.vsum;
            s.prior = prev.prior;
          end
          s.last = (i == len - 1);
          send_slot(s, idle);
          if (s.present) prev = s;
        end
      end
      drain();
    end
  endtask

  // Each pick is compared with the oldest pending one. out_valid is a one-cycle
  // strobe, sampled here before this edge's updates land.
  always @(posedge clk) begin : check_picks
    pick_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: pick with none pending: expected nothing, got action %0d found %0b",
                 $time, out_pick_action, out_child_found);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        picks_checked++;
        if (out_pick_action !== want.action) begin
          $display("%0t: pick action expected %0d, got %0d", $time, want.action,
                   out_pick_action);
          mismatches++;
        end
        if (out_child_found !== want.found) begin
          $display("%0t: child_found expected %0b, got %0b", $time, want.found,
                   out_child_found);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_slot_nodes();
    test_multi_slot_nodes();
    test_gain_extremes();
    test_random_nodes();
    $display("Sent %0d slot requests in %0d node runs under %0d gain writes.", slots_sent,
             nodes_sent, gain_writes);
    $display("Checked %0d picks, found %0d mismatches.", picks_checked, mismatches);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("puct_child_select_test passed");
    end else begin
      $display("puct_child_select_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_divider.sv
rtl/pcs_isqrt.sv
rtl/puct_child_select.sv
dv/puct_child_select_test.sv
